@@ hdl/bar_pkg.sv @@
// ----------------------------------------------------------------------------
// bar_pkg
// Shared types and constants for the button auto-repeat block.
// ----------------------------------------------------------------------------
package bar_pkg;

   // Field widths
   localparam int RAW_W   = 16;
   localparam int TICK_W  = 32;
   localparam int DELAY_W = 16;

   // Default button count
   localparam int BUTTONS_DEF = 16;

   // Register reset values
   localparam logic [DELAY_W-1:0] FIRST_DELAY_RST     = 16'd50;
   localparam logic [DELAY_W-1:0] REPEAT_INTERVAL_RST = 16'd10;

   // Register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DELAY     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_INTERVAL = 1'b1;

   // Timing settings handed to every button lane
   typedef struct packed {
      logic [DELAY_W-1:0] first_delay;
      logic [DELAY_W-1:0] repeat_interval;
   } cfg_type;

endpackage

@@ hdl/button_auto_repeat_top.sv @@
// ----------------------------------------------------------------------------
// button_auto_repeat_top
// Typematic auto-repeat for a pad of active-low buttons.
// ----------------------------------------------------------------------------
// Takes one poll item per clock unless stalled, and returns one result item
// per poll via the input register, then the result register. The rate is set
// by the per-button lane, which does one 32-bit deadline compare and one add
// per cycle; all lanes run in parallel. A stalled result holds while one more
// poll waits in the input register. Timing registers: index 0 is first_delay,
// index 1 is repeat_interval; write only while the block is idle.
// ----------------------------------------------------------------------------
module button_auto_repeat_top #(
   parameter int BUTTONS = bar_pkg::BUTTONS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // poll channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bar_pkg::RAW_W-1:0]     req_raw_buttons,
   input  logic [bar_pkg::TICK_W-1:0]    req_tick_now,
   input  logic                          req_ignore_request,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bar_pkg::RAW_W-1:0]     rsp_held_mask,
   output logic [bar_pkg::RAW_W-1:0]     rsp_repeat_mask,
   // register write port
   input  logic                          csr_we,
   input  logic [bar_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bar_pkg::DELAY_W-1:0]   csr_wdata
);

   localparam int RAW_W = bar_pkg::RAW_W;

   bar_pkg::cfg_type cfg_ff;

   logic                         s1_vld_ff;
   logic [RAW_W-1:0]             s1_held_ff;
   logic [bar_pkg::TICK_W-1:0]   s1_tick_ff;
   logic                         s1_ign_ff;

   logic                         rsp_vld_ff;
   logic [RAW_W-1:0]             rsp_held_ff, rsp_held_in;
   logic [RAW_W-1:0]             rsp_rep_ff,  rsp_rep_in;

   logic                         ignoring_ff, ignoring_in;
   logic                         ign_eff;
   logic                         step;
   logic                         req_fire;
   logic [BUTTONS-1:0]           fire;
   logic [RAW_W-1:0]             fire_raw;

   // Register write port
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_delay     <= bar_pkg::FIRST_DELAY_RST;
         cfg_ff.repeat_interval <= bar_pkg::REPEAT_INTERVAL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            bar_pkg::CSR_FIRST_DELAY:     cfg_ff.first_delay     <= csr_wdata;
            bar_pkg::CSR_REPEAT_INTERVAL: cfg_ff.repeat_interval <= csr_wdata;
         endcase
      end
   end

   // Handshake: evaluate stage moves when the result register is free
   assign step      = s1_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || step;
   assign req_fire  = req_valid && req_ready;

   // Input register: store held bits active high
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_ready) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_held_ff <= ~req_raw_buttons;
         s1_tick_ff <= req_tick_now;
         s1_ign_ff  <= req_ignore_request;
      end
   end

   // Button lanes; buttons above the raw field read as released
   for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
      logic lane_held;
      if (i < RAW_W) begin : g_in
         assign lane_held = s1_held_ff[i];
      end else begin : g_out
         assign lane_held = 1'b0;
      end
      bar_lane u_lane (
         .clock (clock),
         .reset (reset),
         .step  (step),
         .held  (lane_held),
         .tick  (s1_tick_ff),
         .cfg   (cfg_ff),
         .fire  (fire[i])
      );
   end

   // Fire mask carried on the 16-bit result field
   for (genvar j = 0; j < RAW_W; j++) begin : g_fmask
      if (j < BUTTONS) begin : g_on
         assign fire_raw[j] = fire[j];
      end else begin : g_off
         assign fire_raw[j] = 1'b0;
      end
   end

   // Ignore-until-released and output blanking
   assign ign_eff = ignoring_ff || s1_ign_ff;

   always_comb begin
      ignoring_in = ign_eff && (s1_held_ff != '0);
      rsp_held_in = ign_eff ? '0 : s1_held_ff;
      rsp_rep_in  = ign_eff ? '0 : fire_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ignoring_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (step) begin
            ignoring_ff <= ignoring_in;
         end
         if (step) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_held_ff <= rsp_held_in;
         rsp_rep_ff  <= rsp_rep_in;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_held_mask   = rsp_held_ff;
   assign rsp_repeat_mask = rsp_rep_ff;

`ifndef ASSERT_OFF
   // A repeating button is always reported as held
   a_rep_in_held: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_rep_ff & ~rsp_held_ff) == '0)
      else $error("repeat bit without held bit");

   // An ignore request blanks the result of its own poll
   a_ignore_blanks: assert property (@(posedge clock) disable iff (reset)
      step && s1_ign_ff |=> rsp_held_ff == '0 && rsp_rep_ff == '0)
      else $error("ignored poll produced output");

   // Ignoring ends once a poll sees every button released
   a_ignore_ends: assert property (@(posedge clock) disable iff (reset)
      step && s1_held_ff == '0 |=> !ignoring_ff)
      else $error("ignore state survived full release");
`endif

endmodule

@@ hdl/bar_lane.sv @@
// ----------------------------------------------------------------------------
// bar_lane
// Per-button typematic state: press tracking, repeat deadline, fire decision.
// ----------------------------------------------------------------------------
module bar_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic                      held,
   input  logic [bar_pkg::TICK_W-1:0] tick,
   input  bar_pkg::cfg_type          cfg,
   output logic                      fire
);

   logic                       pressed_ff,  pressed_in;
   logic [bar_pkg::TICK_W-1:0] deadline_ff, deadline_in;
   logic [bar_pkg::TICK_W-1:0] fd_ext, ri_ext;

   assign fd_ext = {{(bar_pkg::TICK_W-bar_pkg::DELAY_W){1'b0}}, cfg.first_delay};
   assign ri_ext = {{(bar_pkg::TICK_W-bar_pkg::DELAY_W){1'b0}}, cfg.repeat_interval};

   // Next state and fire for this poll
   always_comb begin
      pressed_in  = pressed_ff;
      deadline_in = deadline_ff;
      fire        = 1'b0;
      if (held) begin
         if (pressed_ff) begin
            if (deadline_ff < tick) begin
               fire        = 1'b1;
               deadline_in = tick + ri_ext;
            end
         end else begin
            pressed_in  = 1'b1;
            fire        = 1'b1;
            deadline_in = tick + fd_ext;
         end
      end else begin
         pressed_in  = 1'b0;
         deadline_in = tick - ri_ext;
      end
   end

   // State update on each processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff  <= 1'b0;
         deadline_ff <= '0;
      end else if (step) begin
         pressed_ff  <= pressed_in;
         deadline_ff <= deadline_in;
      end
   end

`ifndef ASSERT_OFF
   // A poll of a released button leaves it unpressed
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      step && !held |=> !pressed_ff)
      else $error("lane still pressed after release");

   // A new press always fires and arms the first-delay deadline
   a_first_press: assert property (@(posedge clock) disable iff (reset)
      step && held && !pressed_ff |=> pressed_ff && deadline_ff == $past(tick + fd_ext))
      else $error("first press did not arm deadline");

   // Firing happens only for a held button
   a_fire_held: assert property (@(posedge clock) disable iff (reset)
      fire |-> held)
      else $error("fire on released button");
`endif

endmodule
